FILE: src/pocm_pkg.sv
// Shared types, codes and defaults for the partial order closure matrix.
package pocm_pkg;

  localparam int MAX_NODES_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int NODE_W  = 5;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 6'd32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EQUAL = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] lesser_node;
    logic [NODE_W-1:0] greater_node;
  } pocm_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              related;
    logic              order_strict;
  } pocm_out_t;

endpackage

FILE: src/partial_order_closure_matrix_top.sv
// Top level of the partial order closure matrix: sequencer, row and column stores.
//
// Usage:
//  - Command channel: an item transfers at a rising edge with start high and
//    busy low. Commands are insert (lesser < greater), query, clear, and a
//    no-op code that only reports strictness.
//  - Result channel: out_valid strobes for exactly one cycle per item with
//    status, related and order_strict. The receiver cannot stall; the result
//    is gone after that cycle.
//  - Config: cfg_we writes node_count (n) from cfg_data; do it only while idle.
//  - The relation is held twice: a row store (bit j of row i: i below j) and
//    its transpose, a column store. Every pass walks rows 0..n-1 once through
//    a single read port on each store; the same row/column pair both merges
//    an insert and feeds the strictness check, so one pass does both.
//  - Timing: clear reports in the next cycle. Query, no-op and refused items
//    go straight to the row walk; an insert first passes S_SNAP_RD and
//    S_SNAP_CAP to fetch the snapshot row of greater and column of lesser.
//    busy stays high until the result is shown.
//  - Reset: clears the per-row valid flags, so both stores read as empty at
//    once; node_count returns to 32. Clear does the same to the flags.
module partial_order_closure_matrix_top #(
  parameter int MAX_NODES = pocm_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  pocm_pkg::pocm_in_t               in_item,
  output logic                             out_valid,
  output pocm_pkg::pocm_out_t              out_item,
  input  logic                             cfg_we,
  input  logic [pocm_pkg::COUNT_W-1:0]     cfg_data
);

  import pocm_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SNAP_RD,
    S_SNAP_CAP,
    S_PASS
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     node_count_r, node_count_nxt;
  logic [NODE_W-1:0]      lo_r, lo_nxt;
  logic [NODE_W-1:0]      hi_r, hi_nxt;
  logic [STAT_W-1:0]      status_r, status_nxt;
  logic                   do_ins_r, do_ins_nxt;
  logic                   do_query_r, do_query_nxt;
  logic [MAX_NODES-1:0]   above_r, above_nxt;
  logic [MAX_NODES-1:0]   below_r, below_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic                   pend_r, pend_nxt;
  logic [AW-1:0]          pend_k_r, pend_k_nxt;
  logic                   strict_r, strict_nxt;
  logic                   related_r, related_nxt;
  logic [MAX_NODES-1:0]   valid_r, valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pocm_out_t              out_r, out_nxt;

  logic [CW-1:0]          n_cnt;
  logic [MAX_NODES-1:0]   use_mask;
  logic                   accept;
  logic                   in_range;
  logic [AW-1:0]          lo_a, hi_a;
  logic                   rd_go;
  logic                   ram_re;
  logic [AW-1:0]          row_raddr, col_raddr;
  logic [MAX_NODES-1:0]   row_rdata, col_rdata;
  logic [MAX_NODES-1:0]   row_old, col_old, row_new, col_new;
  logic                   viol;
  logic                   ram_we;

  // Nodes in use: node_count clipped to the store size.
  assign n_cnt = (8'(node_count_r) > 8'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_r);

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      use_mask[j] = (8'(j) < 8'(n_cnt));
    end
  end

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign in_range = (8'(in_item.lesser_node) < 8'(n_cnt)) &&
                    (8'(in_item.greater_node) < 8'(n_cnt));

  assign lo_a = AW'(lo_r);
  assign hi_a = AW'(hi_r);

  // Pass issue: one row/column read per cycle while rows remain.
  assign rd_go     = (state_r == S_PASS) && (k_r < n_cnt);
  assign ram_re    = (state_r == S_SNAP_RD) || rd_go;
  assign row_raddr = (state_r == S_SNAP_RD) ? hi_a : k_r[AW-1:0];
  assign col_raddr = (state_r == S_SNAP_RD) ? lo_a : k_r[AW-1:0];

  // Rows never written since the last clear read as zero.
  assign row_old = valid_r[pend_k_r] ? row_rdata : '0;
  assign col_old = valid_r[pend_k_r] ? col_rdata : '0;

  // Merge: row k gains the snapshot above set if k is lesser or below it;
  // column k gains the below set if k is greater or above it.
  assign row_new = row_old | ((do_ins_r && below_r[pend_k_r]) ? above_r : '0);
  assign col_new = col_old | ((do_ins_r && above_r[pend_k_r]) ? below_r : '0);
  assign viol    = |(row_new & col_new & use_mask & ~(MAX_NODES'(1) << pend_k_r));
  assign ram_we  = (state_r == S_PASS) && pend_r && do_ins_r;

  pocm_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_k_r),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  pocm_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_k_r),
    .wdata (col_new),
    .re    (ram_re),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    status_nxt     = status_r;
    do_ins_nxt     = do_ins_r;
    do_query_nxt   = do_query_r;
    above_nxt      = above_r;
    below_nxt      = below_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    pend_k_nxt     = pend_k_r;
    strict_nxt     = strict_r;
    related_nxt    = related_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;

    if (cfg_we) begin
      node_count_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          lo_nxt       = in_item.lesser_node;
          hi_nxt       = in_item.greater_node;
          status_nxt   = ST_DONE;
          do_ins_nxt   = 1'b0;
          do_query_nxt = 1'b0;
          k_nxt        = '0;
          pend_nxt     = 1'b0;
          strict_nxt   = 1'b1;
          related_nxt  = 1'b0;
          case (in_item.command)
            CMD_INSERT: begin
              if (!in_range) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_PASS;
              end else if (in_item.lesser_node == in_item.greater_node) begin
                status_nxt = ST_EQUAL;
                state_nxt  = S_PASS;
              end else begin
                do_ins_nxt = 1'b1;
                state_nxt  = S_SNAP_RD;
              end
            end
            CMD_QUERY: begin
              if (!in_range) begin
                status_nxt = ST_RANGE;
              end else begin
                do_query_nxt = 1'b1;
              end
              state_nxt = S_PASS;
            end
            CMD_CLEAR: begin
              // Empty relation is strict; report at once.
              valid_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_DONE, related: 1'b0, order_strict: 1'b1};
            end
            CMD_NOP: begin
              state_nxt = S_PASS;
            end
            default: begin
              state_nxt = S_PASS;
            end
          endcase
        end
      end

      S_SNAP_RD: begin
        state_nxt = S_SNAP_CAP;
      end

      S_SNAP_CAP: begin
        above_nxt = ((valid_r[hi_a] ? row_rdata : '0) | (MAX_NODES'(1) << hi_a)) & use_mask;
        below_nxt = ((valid_r[lo_a] ? col_rdata : '0) | (MAX_NODES'(1) << lo_a)) & use_mask;
        state_nxt = S_PASS;
      end

      S_PASS: begin
        pend_nxt   = rd_go;
        pend_k_nxt = k_r[AW-1:0];
        if (rd_go) begin
          k_nxt = k_r + CW'(1);
        end
        if (pend_r) begin
          if (viol) begin
            strict_nxt = 1'b0;
          end
          if (do_query_r && (pend_k_r == lo_a)) begin
            related_nxt = row_old[hi_a];
          end
          if (do_ins_r) begin
            valid_nxt[pend_k_r] = 1'b1;
          end
        end
        if (!rd_go && !pend_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: status_r, related: related_r, order_strict: strict_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      k_r          <= '0;
      do_ins_r     <= 1'b0;
      do_query_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
      k_r          <= k_nxt;
      do_ins_r     <= do_ins_nxt;
      do_query_r   <= do_query_nxt;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    status_r  <= status_nxt;
    above_r   <= above_nxt;
    below_r   <= below_nxt;
    pend_k_r  <= pend_k_nxt;
    strict_r  <= strict_nxt;
    related_r <= related_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A clear transfer reports done and strict in the next cycle.
  a_clear_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command == CMD_CLEAR) |=>
      (out_valid && out_item.order_strict && out_item.status == ST_DONE))
    else $error("clear did not report a strict result");

  // A result is only shown once the sequencer is back to idle.
  a_result_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // The row walk never runs past the nodes in use.
  a_pass_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS) |-> (k_r <= n_cnt))
    else $error("row counter beyond node count");

  // The stores are only written by an accepted insert.
  a_write_insert : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (do_ins_r && status_r == ST_DONE))
    else $error("store write outside an accepted insert");

endmodule

FILE: src/pocm_ram.sv
// Generic single write port, single read port RAM with registered read.
module pocm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
